>>> hw/rtl/ctt_pkg.sv
`timescale 1ns / 1ps
package ctt_pkg;

	// Defaults for the top-level parameters
	localparam int TASK_SLOTS_DEF        = 15;
	localparam int STAT_LEVELS_DEF       = 16;
	localparam int HISTORY_PER_LEVEL_DEF = 16;

	// Field widths
	localparam int CMD_W     = 2;
	localparam int TIME_W    = 32;
	localparam int SLOT_IN_W = 4;
	localparam int WORK_W    = 32;
	localparam int TARGET_W  = 5;
	localparam int RUNNING_W = 4;
	localparam int STATUS_W  = 2;

	// Statistics widths
	localparam int CNT_W   = 9;
	localparam int SUM_W   = 32;
	localparam int RATE_W  = 24;
	localparam int INTEG_W = 64;
	localparam int FRAC_W  = 16;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Divider widths
	localparam int DIV_N_W  = 64;
	localparam int DIV_D_W  = 32;
	localparam int DIV_IT_W = 7;

	// APB port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_INITIAL_TARGET = 1'b0;

	// Target limits
	localparam logic [TARGET_W-1:0] TARGET_MIN   = 5'd2;
	localparam logic [TARGET_W-1:0] TARGET_MAX   = 5'd16;
	localparam logic [TARGET_W-1:0] TARGET_RESET = 5'd2;

	typedef enum logic [CMD_W-1:0] {
		CMD_START  = 2'd0,
		CMD_FINISH = 2'd1,
		CMD_QUERY  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 2'd0,
		ST_START_BUSY  = 2'd1,
		ST_FINISH_IDLE = 2'd2
	} status_t;

	typedef struct packed {
		logic [TIME_W-1:0]  start_time;
		logic [INTEG_W-1:0] integ;
	} slot_entry_t;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic [SUM_W-1:0] sum;
	} lvl_entry_t;

	typedef struct packed {
		logic                start;
		logic [DIV_N_W-1:0]  dividend;
		logic [DIV_D_W-1:0]  divisor;
		logic [DIV_IT_W-1:0] iters;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [DIV_N_W-1:0] quotient;
		logic [DIV_D_W-1:0] remainder;
	} div_rsp_t;

	function automatic logic [TARGET_W-1:0] clamp_target(input logic [TARGET_W-1:0] v);
		logic [TARGET_W-1:0] r;
		r = v;
		if (v < TARGET_MIN) r = TARGET_MIN;
		else if (v > TARGET_MAX) r = TARGET_MAX;
		return r;
	endfunction

endpackage

>>> hw/rtl/ctt_ifs.sv
`timescale 1ns / 1ps
interface ctt_cmd_if;
	import ctt_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CMD_W-1:0]     command;
	logic [TIME_W-1:0]    time_us;
	logic [SLOT_IN_W-1:0] task_slot;
	logic [WORK_W-1:0]    work_us;
	modport source (output valid, command, time_us, task_slot, work_us, input ready);
	modport sink (input valid, command, time_us, task_slot, work_us, output ready);
endinterface

interface ctt_res_if;
	import ctt_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [TARGET_W-1:0]  target;
	logic [RUNNING_W-1:0] running;
	logic [STATUS_W-1:0]  status;
	modport source (output valid, target, running, status, input ready);
	modport sink (input valid, target, running, status, output ready);
endinterface

>>> hw/rtl/ctt_ram.sv
`timescale 1ns / 1ps
module ctt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port, registered read port that holds between reads
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_data <= mem[rd_addr];
	end

endmodule

>>> hw/rtl/ctt_div.sv
`timescale 1ns / 1ps
module ctt_div (
	input  logic              clk,
	input  logic              arst_n,
	input  ctt_pkg::div_req_t req,
	output ctt_pkg::div_rsp_t rsp
);
	import ctt_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [DIV_IT_W-1:0] cnt_q;
	logic [DIV_N_W-1:0]  quo_q;
	logic [DIV_D_W-1:0]  rem_q;
	logic [DIV_D_W-1:0]  dvs_q;
	logic [DIV_D_W:0]    trial;
	logic                ge;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	assign trial = {rem_q, quo_q[DIV_N_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= req.iters;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_IT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Quotient and remainder; the dividend comes in aligned to the top bit
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_N_W-2:0], ge};
			rem_q <= ge ? DIV_D_W'(trial - {1'b0, dvs_q}) : DIV_D_W'(trial);
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

>>> hw/rtl/concurrency_target_tuner_core.sv
`timescale 1ns / 1ps
// Concurrency target tuner. Takes one transaction at a time and returns one result per
// transaction. A finish runs one 64-bit average concurrency division and one 48-bit work
// rate division, each one quotient bit per cycle in the single shared radix-2 divider;
// when the history is halved, each non-empty level in use adds a multiply and a 41-bit
// division. A query on a stale target runs two 32-bit divisions for each non-empty level
// in use above level 0. Level statistics and task slots live in two one-port-read RAMs;
// level statistics are cleared at reset through per-level valid bits, so no clearing
// pass runs.
module concurrency_target_tuner_core #(
	parameter int TASK_SLOTS        = ctt_pkg::TASK_SLOTS_DEF,
	parameter int STAT_LEVELS       = ctt_pkg::STAT_LEVELS_DEF,
	parameter int HISTORY_PER_LEVEL = ctt_pkg::HISTORY_PER_LEVEL_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ctt_pkg::PADDR_W-1:0] paddr,
	input  logic [ctt_pkg::PDATA_W-1:0] pwdata,
	output logic [ctt_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	ctt_cmd_if.sink                     cmd,
	ctt_res_if.source                   res
);
	import ctt_pkg::*;

	localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int RUN_W  = $clog2(TASK_SLOTS + 1);
	localparam int LVL_W  = $clog2(STAT_LEVELS);
	localparam int LVLS_W = $clog2(STAT_LEVELS + 1);
	localparam int PROD_W = TIME_W + RUN_W;
	localparam int MUL_W  = SUM_W + CNT_W;
	localparam int CMP_W  = 10;
	localparam int BAR_W  = SUM_W + 2;

	typedef enum logic [16:0] {
		S_IDLE      = 17'h00001,
		S_START     = 17'h00002,
		S_FIN_RD    = 17'h00004,
		S_FIN_DIV   = 17'h00008,
		S_AVG_WAIT  = 17'h00010,
		S_RATE_WAIT = 17'h00020,
		S_LVL_WR    = 17'h00040,
		S_H_RD      = 17'h00080,
		S_H_CALC    = 17'h00100,
		S_H_MUL     = 17'h00200,
		S_H_WAIT    = 17'h00400,
		S_Q_RD      = 17'h00800,
		S_Q_MEAN    = 17'h01000,
		S_Q_WAIT1   = 17'h02000,
		S_Q_WAIT2   = 17'h04000,
		S_Q_PICK    = 17'h08000,
		S_DONE      = 17'h10000
	} state_t;

	state_t state_q;

	// Control state
	logic [TASK_SLOTS-1:0]  busy_q;
	logic [STAT_LEVELS-1:0] lvl_valid_q;
	logic [RUN_W-1:0]       running_q;
	logic [LVLS_W-1:0]      levels_q;
	logic [TIME_W-1:0]      last_q;
	logic [INTEG_W-1:0]     integ_q;
	logic [CNT_W-1:0]       total_q;
	logic [TARGET_W-1:0]    target_q;
	logic                   fresh_q;
	logic [TARGET_W-1:0]    init_q;
	logic                   res_valid_q;

	// Datapath registers
	logic [TIME_W-1:0]      time_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [WORK_W-1:0]      work_q;
	status_t                status_q;
	logic [PROD_W-1:0]      prod_q;
	logic [TIME_W-1:0]      dur_q;
	logic [INTEG_W-1:0]     sint_q;
	logic [LVL_W-1:0]       lidx_q;
	logic [CNT_W-1:0]       n_q;
	logic [CNT_W-1:0]       keep_q;
	logic [MUL_W-1:0]       mul_q;
	logic [SUM_W-1:0]       f_q;
	logic signed [BAR_W-1:0] bar_q;
	logic signed [BAR_W-1:0] cliff_q;
	logic [LVL_W-1:0]       drop_q;
	logic [STAT_LEVELS-1:0] nz_q;
	logic [TARGET_W-1:0]    res_target_q;
	logic [RUNNING_W-1:0]   res_running_q;
	logic [STATUS_W-1:0]    res_status_q;

	// Memory and divider ports
	logic        slot_rd_en, slot_wr_en;
	logic [SLOT_W-1:0] slot_rd_addr;
	slot_entry_t slot_wr_data, slot_rd_data;
	logic        lvl_rd_en, lvl_wr_en;
	logic [LVL_W-1:0] lvl_rd_addr;
	lvl_entry_t  lvl_wr_data, lvl_rd_data, lvl_cur;
	div_req_t    div_req;
	div_rsp_t    div_rsp;

	// Combinational helpers
	logic              cmd_acc;
	logic              slot_in_range;
	logic [SLOT_W-1:0] slot_idx_in;
	logic              busy_in;
	logic [INTEG_W-1:0] integ_next;
	logic              grow;
	logic              inc_round;
	logic [CMP_W-1:0]  q_round, lv_m1, hi, lvl_wide;
	logic [LVL_W-1:0]  lvl_sel;
	logic [RATE_W-1:0] rate;
	logic [SUM_W:0]    sum_wide;
	logic [SUM_W-1:0]  sum_new;
	logic [CNT_W-1:0]  cnt_new, total_inc, n_cur, lost, keep;
	logic              halve_go;
	logic              loop_last, loop_step;
	logic              upd_en;
	logic [SUM_W-1:0]  upd_f, upd_d;
	logic signed [BAR_W-1:0] f_s;
	logic [LVL_W-1:0]  t_pick, t_up, t_dn;
	logic [LVL_W:0]    t_sel;
	logic              cfg_wr;
	logic [TARGET_W-1:0] cfg_val;

	ctt_ram #(.WIDTH($bits(slot_entry_t)), .DEPTH(TASK_SLOTS)) u_slot_ram (
		.clk     (clk),
		.wr_en   (slot_wr_en),
		.wr_addr (slot_q),
		.wr_data (slot_wr_data),
		.rd_en   (slot_rd_en),
		.rd_addr (slot_rd_addr),
		.rd_data (slot_rd_data)
	);

	ctt_ram #(.WIDTH($bits(lvl_entry_t)), .DEPTH(STAT_LEVELS)) u_lvl_ram (
		.clk     (clk),
		.wr_en   (lvl_wr_en),
		.wr_addr (lidx_q),
		.wr_data (lvl_wr_data),
		.rd_en   (lvl_rd_en),
		.rd_addr (lvl_rd_addr),
		.rd_data (lvl_rd_data)
	);

	ctt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Input decode
	assign cmd.ready     = (state_q == S_IDLE);
	assign cmd_acc       = cmd.valid && cmd.ready;
	assign slot_in_range = 32'(cmd.task_slot) < TASK_SLOTS;
	assign slot_idx_in   = SLOT_W'(cmd.task_slot);
	assign busy_in       = slot_in_range && busy_q[slot_idx_in];

	// Slot store: read at acceptance, written on a start
	assign integ_next   = integ_q + INTEG_W'(prod_q);
	assign slot_rd_en   = cmd_acc;
	assign slot_rd_addr = slot_idx_in;
	assign slot_wr_en   = (state_q == S_START);
	assign slot_wr_data = '{start_time: time_q, integ: integ_next};
	assign grow = (CMP_W'(running_q) + CMP_W'(1) == CMP_W'(levels_q))
		&& (CMP_W'(levels_q) < CMP_W'(STAT_LEVELS));

	// Round and clamp the average concurrency
	assign inc_round = {div_rsp.remainder, 1'b0} >= {1'b0, dur_q};
	assign q_round   = (|div_rsp.quotient[DIV_N_W-1:CNT_W]) ? CMP_W'(CNT_MAX)
		: CMP_W'(div_rsp.quotient[CNT_W-1:0]) + CMP_W'(inc_round);
	assign lv_m1     = CMP_W'(levels_q) - CMP_W'(1);
	assign hi        = (lv_m1 < CMP_W'(1)) ? CMP_W'(1)
		: ((lv_m1 > CMP_W'(STAT_LEVELS - 1)) ? CMP_W'(STAT_LEVELS - 1) : lv_m1);
	assign lvl_wide  = (q_round < CMP_W'(1)) ? CMP_W'(1) : ((q_round > hi) ? hi : q_round);
	assign lvl_sel   = LVL_W'(lvl_wide);

	// Record a sample
	assign lvl_cur   = lvl_valid_q[lidx_q] ? lvl_rd_data : '0;
	assign rate      = (|div_rsp.quotient[DIV_N_W-1:RATE_W]) ? '1 : div_rsp.quotient[RATE_W-1:0];
	assign sum_wide  = (SUM_W+1)'(lvl_cur.sum) + (SUM_W+1)'(rate);
	assign sum_new   = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
	assign cnt_new   = (lvl_cur.cnt == CNT_MAX) ? lvl_cur.cnt : lvl_cur.cnt + 1'b1;
	assign total_inc = (total_q == CNT_MAX) ? total_q : total_q + 1'b1;
	assign halve_go  = 32'(total_inc) >= 32'(levels_q) * 32'(HISTORY_PER_LEVEL);

	// Halving of one level
	assign n_cur = lvl_cur.cnt;
	assign lost  = CNT_W'(((CNT_W+1)'(n_cur) + (CNT_W+1)'(1)) >> 1);
	assign keep  = n_cur - lost;

	// Level walk control
	assign loop_last = (CMP_W'(lidx_q) == lv_m1);
	always_comb begin
		loop_step = 1'b0;
		upd_en    = 1'b0;
		upd_f     = f_q;
		upd_d     = div_rsp.quotient[SUM_W-1:0];
		unique case (state_q)
			S_H_CALC: loop_step = (n_cur == '0);
			S_H_WAIT: loop_step = div_rsp.done;
			S_Q_MEAN: begin
				loop_step = (lidx_q == '0) || (n_cur == '0);
				upd_en    = (lidx_q != '0) && (n_cur == '0);
				upd_f     = '0;
				upd_d     = '0;
			end
			S_Q_WAIT2: begin
				loop_step = div_rsp.done;
				upd_en    = div_rsp.done;
			end
			default: ;
		endcase
	end
	assign f_s = BAR_W'(signed'({2'b00, upd_f}));

	// Level pick and neighbour jitter; the step up may reach STAT_LEVELS
	assign t_pick = (drop_q != '0) ? drop_q - 1'b1 : LVL_W'(lv_m1);
	assign t_up   = t_pick + 1'b1;
	assign t_dn   = t_pick - 1'b1;
	always_comb begin
		if (!nz_q[t_pick]) t_sel = (LVL_W+1)'(t_pick);
		else if ((CMP_W'(t_pick) + CMP_W'(1) == CMP_W'(levels_q)) || !nz_q[t_up])
			t_sel = (LVL_W+1)'(t_pick) + 1'b1;
		else if ((t_pick > LVL_W'(1)) && !nz_q[t_dn]) t_sel = (LVL_W+1)'(t_dn);
		else t_sel = (LVL_W+1)'(t_pick);
	end

	// Level store ports
	always_comb begin
		lvl_rd_en   = 1'b0;
		lvl_rd_addr = lidx_q;
		lvl_wr_en   = 1'b0;
		lvl_wr_data = '0;
		unique case (state_q)
			S_AVG_WAIT: begin
				lvl_rd_en   = div_rsp.done;
				lvl_rd_addr = lvl_sel;
			end
			S_H_RD, S_Q_RD: lvl_rd_en = 1'b1;
			S_LVL_WR: begin
				lvl_wr_en   = 1'b1;
				lvl_wr_data = '{cnt: cnt_new, sum: sum_new};
			end
			S_H_CALC: lvl_wr_en = (n_cur == '0);
			S_H_WAIT: begin
				lvl_wr_en   = div_rsp.done;
				lvl_wr_data = '{cnt: keep_q,
					sum: (keep_q == '0) ? '0 : div_rsp.quotient[SUM_W-1:0]};
			end
			default: ;
		endcase
	end

	// Divider requests
	always_comb begin
		div_req = '0;
		unique case (state_q)
			S_FIN_DIV: begin
				div_req.start    = 1'b1;
				div_req.dividend = integ_q - sint_q;
				div_req.divisor  = dur_q;
				div_req.iters    = DIV_IT_W'(DIV_N_W);
			end
			S_AVG_WAIT: begin
				div_req.start    = div_rsp.done;
				div_req.dividend = {work_q, {(DIV_N_W-WORK_W){1'b0}}};
				div_req.divisor  = dur_q;
				div_req.iters    = DIV_IT_W'(WORK_W + FRAC_W);
			end
			S_H_MUL: begin
				div_req.start    = 1'b1;
				div_req.dividend = {mul_q, {(DIV_N_W-MUL_W){1'b0}}};
				div_req.divisor  = DIV_D_W'(n_q);
				div_req.iters    = DIV_IT_W'(MUL_W);
			end
			S_Q_MEAN: begin
				div_req.start    = (lidx_q != '0) && (n_cur != '0);
				div_req.dividend = {lvl_cur.sum, {(DIV_N_W-SUM_W){1'b0}}};
				div_req.divisor  = DIV_D_W'(n_cur);
				div_req.iters    = DIV_IT_W'(SUM_W);
			end
			S_Q_WAIT1: begin
				div_req.start    = div_rsp.done;
				div_req.dividend = {div_rsp.quotient[SUM_W-1:0], {(DIV_N_W-SUM_W){1'b0}}};
				div_req.divisor  = DIV_D_W'(lidx_q) + DIV_D_W'(1);
				div_req.iters    = DIV_IT_W'(SUM_W);
			end
			default: ;
		endcase
	end

	// Configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && (paddr[2] == REG_INITIAL_TARGET);
	assign cfg_val = clamp_target(pwdata[TARGET_W-1:0]);
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_INITIAL_TARGET) prdata = PDATA_W'(init_q);
	end

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			busy_q      <= '0;
			lvl_valid_q <= '0;
			running_q   <= '0;
			levels_q    <= LVLS_W'(1);
			last_q      <= '0;
			integ_q     <= '0;
			total_q     <= '0;
			target_q    <= TARGET_RESET;
			fresh_q     <= 1'b1;
			init_q      <= TARGET_RESET;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && res.ready && (state_q != S_DONE)) res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_acc) begin
						case (cmd.command)
							CMD_START:  state_q <= busy_in || !slot_in_range ? S_DONE : S_START;
							CMD_FINISH: state_q <= busy_in ? S_FIN_RD : S_DONE;
							CMD_QUERY:  state_q <= fresh_q ? S_DONE : S_Q_RD;
							default:    state_q <= S_DONE;
						endcase
					end
				end
				S_START: begin
					if (grow) begin
						lvl_valid_q[LVL_W'(levels_q)] <= 1'b0;
						levels_q <= levels_q + 1'b1;
					end
					integ_q         <= integ_next;
					last_q          <= time_q;
					busy_q[slot_q]  <= 1'b1;
					running_q       <= running_q + 1'b1;
					state_q         <= S_DONE;
				end
				S_FIN_RD: begin
					integ_q <= integ_next;
					last_q  <= time_q;
					state_q <= S_FIN_DIV;
				end
				S_FIN_DIV: state_q <= S_AVG_WAIT;
				S_AVG_WAIT: if (div_rsp.done) state_q <= S_RATE_WAIT;
				S_RATE_WAIT: if (div_rsp.done) state_q <= S_LVL_WR;
				S_LVL_WR: begin
					lvl_valid_q[lidx_q] <= 1'b1;
					total_q        <= total_inc;
					fresh_q        <= 1'b0;
					busy_q[slot_q] <= 1'b0;
					if (running_q != '0) running_q <= running_q - 1'b1;
					state_q <= halve_go ? S_H_RD : S_DONE;
				end
				S_H_RD: state_q <= S_H_CALC;
				S_H_CALC: begin
					total_q <= (total_q >= lost) ? total_q - lost : '0;
					if (n_cur == '0) lvl_valid_q[lidx_q] <= 1'b1;
					if (loop_step) state_q <= loop_last ? S_DONE : S_H_RD;
					else state_q <= S_H_MUL;
				end
				S_H_MUL: state_q <= S_H_WAIT;
				S_H_WAIT: begin
					if (loop_step) begin
						lvl_valid_q[lidx_q] <= 1'b1;
						state_q <= loop_last ? S_DONE : S_H_RD;
					end
				end
				S_Q_RD: state_q <= S_Q_MEAN;
				S_Q_MEAN: begin
					if (loop_step) state_q <= loop_last ? S_Q_PICK : S_Q_RD;
					else state_q <= S_Q_WAIT1;
				end
				S_Q_WAIT1: if (div_rsp.done) state_q <= S_Q_WAIT2;
				S_Q_WAIT2: if (loop_step) state_q <= loop_last ? S_Q_PICK : S_Q_RD;
				S_Q_PICK: begin
					target_q <= TARGET_W'(t_sel);
					fresh_q  <= 1'b1;
					state_q  <= S_DONE;
				end
				S_DONE: begin
					if (!res_valid_q || res.ready) begin
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (cfg_wr) begin
				init_q <= cfg_val;
				if (fresh_q && (total_q == '0)) target_q <= cfg_val;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			time_q  <= cmd.time_us;
			slot_q  <= slot_idx_in;
			work_q  <= cmd.work_us;
			prod_q  <= PROD_W'(cmd.time_us - last_q) * PROD_W'(running_q);
			lidx_q  <= '0;
			bar_q   <= -BAR_W'(65536);
			cliff_q <= -BAR_W'(65536);
			drop_q  <= '0;
			status_q <= ST_OK;
			if (cmd.command == CMD_START && (busy_in || !slot_in_range)) status_q <= ST_START_BUSY;
			if (cmd.command == CMD_FINISH && !busy_in) status_q <= ST_FINISH_IDLE;
		end
		if (state_q == S_FIN_RD) begin
			dur_q  <= (time_q == slot_rd_data.start_time) ? TIME_W'(1)
				: time_q - slot_rd_data.start_time;
			sint_q <= slot_rd_data.integ;
		end
		if ((state_q == S_AVG_WAIT) && div_rsp.done) lidx_q <= lvl_sel;
		if ((state_q == S_LVL_WR) && halve_go) lidx_q <= '0;
		if (state_q == S_H_CALC) begin
			n_q    <= n_cur;
			keep_q <= keep;
			mul_q  <= MUL_W'(lvl_cur.sum) * MUL_W'(keep);
		end
		if (state_q == S_Q_MEAN) nz_q[lidx_q] <= (n_cur != '0);
		if ((state_q == S_Q_WAIT1) && div_rsp.done) f_q <= div_rsp.quotient[SUM_W-1:0];
		if (upd_en) begin
			if (f_s > bar_q) begin
				bar_q   <= f_s - BAR_W'(upd_d >> 2);
				cliff_q <= f_s - BAR_W'(upd_d >> 1);
				drop_q  <= '0;
			end else if ((drop_q == '0) && (f_s < cliff_q)) begin
				drop_q <= lidx_q;
			end
		end
		if (loop_step && !loop_last) lidx_q <= lidx_q + 1'b1;
		if ((state_q == S_DONE) && (!res_valid_q || res.ready)) begin
			res_target_q  <= target_q;
			res_running_q <= RUNNING_W'(running_q);
			res_status_q  <= status_q;
		end
	end

	assign res.valid   = res_valid_q;
	assign res.target  = res_target_q;
	assign res.running = res_running_q;
	assign res.status  = res_status_q;

`ifndef ASSERT_OFF
	a_running_matches_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(busy_q) == 32'(running_q))
		else $error("running count differs from busy slots");

	a_levels_range: assert property (@(posedge clk) disable iff (!arst_n)
		(levels_q >= LVLS_W'(1)) && (CMP_W'(levels_q) <= CMP_W'(STAT_LEVELS)))
		else $error("levels in use out of range");

	a_div_done_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_AVG_WAIT || state_q == S_RATE_WAIT ||
			state_q == S_H_WAIT || state_q == S_Q_WAIT1 || state_q == S_Q_WAIT2))
		else $error("divider finished outside a wait state");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc |=> (state_q != S_IDLE))
		else $error("transaction accepted without starting work");
`endif

endmodule
